FILE: rtl/core/ssat_pkg.sv
// ============================================================================
// ssat_pkg
// Shared types and constants of the sigmoid saturator: curve codes, register
// indexes, port widths and the Q.28 fixed-point constants of the datapath.
// ============================================================================
`default_nettype none

package ssat_pkg;

    // Default sample width of the audio ports.
    localparam int SSAT_SAMPLE_BITS = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 14;
    localparam int KNEE_BITS      = 14;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHAPE_MODE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KNEE       = 1'b1;

    // Curve select. Code 7 is unused and falls back to hard clip.
    typedef enum logic [2:0] {
        SHAPE_CLIP       = 3'd0,
        SHAPE_RATIONAL   = 3'd1,
        SHAPE_CUBIC_RAT  = 3'd2,
        SHAPE_CUBIC      = 3'd3,
        SHAPE_QUARTIC    = 3'd4,
        SHAPE_HEXIC      = 3'd5,
        SHAPE_HEXIC_SOFT = 3'd6
    } t_shape;

    localparam t_shape               SHAPE_RESET = SHAPE_RATIONAL;
    localparam logic [KNEE_BITS-1:0] KNEE_RESET  = 14'd8192;

    // Q.28 magnitude constants.
    localparam logic [63:0] ONE64     = 64'h0000_0000_1000_0000;
    localparam logic [63:0] HALF64    = 64'h0000_0000_0800_0000;
    localparam logic [63:0] TWO64     = 64'h0000_0000_2000_0000;
    localparam logic [63:0] CUBIC_LIM = 64'h0000_0000_1800_0000;
    localparam logic [63:0] RATIO_NUM = 64'h0100_0000_0000_0000;

    // floor(n / 27) = (n * DIV27_MUL) >> DIV27_SHIFT for any 32-bit n.
    localparam logic [32:0] DIV27_MUL   = 33'd5090331611;
    localparam int          DIV27_SHIFT = 37;

    // Shared divider geometry.
    localparam int DIV_STEPS = 30;
    localparam int DEN_BITS  = 38;
    localparam int NUM_BITS  = 58;

    // Per-beat bookkeeping that rides along the pipeline.
    typedef struct packed {
        logic        neg;
        logic [31:0] x;
        logic        lin;
        logic        sat;
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/core/sigmoid_saturator_unit.sv
// ============================================================================
// sigmoid_saturator_unit
// Odd-symmetric soft clipper for signed Q4.x audio samples with a selectable
// curve, producing rounded Q2.x samples within -1.0 .. +1.0.
// ============================================================================
`default_nettype none

// The unit takes one sample beat per clock and returns one result beat per
// sample, in order. The sample passes through the shared restoring divider,
// which resolves one quotient bit per stage over 30 stages, and through the
// multiplier stages that evaluate the curve polynomials before and after it.
// Every stage holds when a result beat waits at the output and is not taken,
// so nothing is lost or repeated; otherwise a new sample is accepted in every
// cycle. Configuration writes (curve select at index 0, knee at index 1) are
// always accepted and should only be issued while no sample is in flight.
module sigmoid_saturator_unit #(
    parameter int SAMPLE_BITS = ssat_pkg::SSAT_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssat_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ssat_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ssat_pkg::*;

    // Stage positions. Stage k computes from the registers of stage k-1.
    localparam int ST_S5   = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_Q    = ST_DIV0 + DIV_STEPS;
    localparam int ST_P7   = ST_Q + 7;
    localparam int NSTG    = ST_Q + 9;

    // Output rounding geometry.
    localparam int          RSH      = (SAMPLE_BITS < 30) ? (30 - SAMPLE_BITS) : 0;
    localparam int          LSH      = (SAMPLE_BITS > 30) ? (SAMPLE_BITS - 30) : 0;
    localparam logic [63:0] RND_HALF = (64'd1 << RSH) >> 1;
    localparam logic [63:0] ONE_OUT  = 64'd1 << (SAMPLE_BITS - 2);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    t_shape               r_shape_mode;
    logic [KNEE_BITS-1:0] r_knee;
    logic [27:0]          w_knee_q;

    assign o_cfg_ready = 1'b1;
    assign w_knee_q    = {r_knee, 14'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode <= SHAPE_RESET;
            r_knee       <= KNEE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHAPE_MODE: r_shape_mode <= t_shape'(i_cfg_data[2:0]);
                CFG_KNEE:       r_knee       <= i_cfg_data[KNEE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the output beat is
    // held. Valid bits shift along with the data.
    // ------------------------------------------------------------------
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en        = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Combinational logic of every stage.
    // ------------------------------------------------------------------
    t_side            r_side [0:NSTG-2];
    t_side            n_side0;
    t_side            n_side5;
    logic             n_lin;
    logic             n_sat;

    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SAMPLE_BITS-1:0] w_mag;

    logic [63:0]      w_pr2;
    logic [34:0]      r_s2_x2, n_s2_x2;
    logic [34:0]      w_s3_sum;
    logic [49:0]      r_s3_pl, n_s3_pl;
    logic [48:0]      r_s3_ph, n_s3_ph;
    logic [66:0]      w_s4_prod;
    logic [DEN_BITS-1:0] r_s4_p, n_s4_p;

    logic [DEN_BITS-1:0] w_d1, w_d2, w_den6;
    logic [32:0]      w_diff;
    logic [NUM_BITS-1:0] r_s5_num, n_s5_num;
    logic [DEN_BITS-1:0] r_s5_den, n_s5_den;

    logic [DEN_BITS-1:0]  w_dv_rem_in [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] w_dv_num_in [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] w_dv_q_in   [0:DIV_STEPS-1];
    logic [DEN_BITS-1:0]  w_dv_den_in [0:DIV_STEPS-1];
    logic [DEN_BITS:0]    w_dv_trial  [0:DIV_STEPS-1];
    logic [DEN_BITS-1:0]  r_dv_rem [0:DIV_STEPS-1], n_dv_rem [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_dv_num [0:DIV_STEPS-1], n_dv_num [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_dv_q   [0:DIV_STEPS-1], n_dv_q   [0:DIV_STEPS-1];
    logic [DEN_BITS-1:0]  r_dv_den [0:DIV_STEPS-1], n_dv_den [0:DIV_STEPS-1];

    logic [DIV_STEPS-1:0] w_q;
    logic [29:0]      w_q6_z;
    logic             w_q6_big;
    logic [29:0]      r_q6_z, n_q6_z;
    logic             r_q6_big;

    logic [29:0]      r_p1_z;
    logic [30:0]      r_p1_z2, n_p1_z2;
    logic             r_p1_big;

    logic [29:0]      r_p2_z;
    logic [30:0]      r_p2_z2;
    logic [31:0]      r_p2_z3, n_p2_z3;
    logic [32:0]      r_p2_z4, n_p2_z4;
    logic             r_p2_big;

    logic [31:0]      w_n27;
    logic [64:0]      w_pr27;
    logic [29:0]      r_p3_z;
    logic [33:0]      r_p3_z5, n_p3_z5;
    logic [34:0]      r_p3_z6, n_p3_z6;
    logic [27:0]      r_p3_t27, n_p3_t27;
    logic [39:0]      r_p3_s4, n_p3_s4;
    logic [39:0]      r_p3_a6, n_p3_a6;
    logic             r_p3_big;

    logic [29:0]      r_p4_z;
    logic [27:0]      r_p4_t27;
    logic [39:0]      r_p4_s4;
    logic [39:0]      r_p4_s6, n_p4_s6;
    logic             r_p4_big;

    logic [29:0]      r_p5_h, n_p5_h;
    logic [58:0]      r_p6_m, n_p6_m;
    logic [29:0]      r_p6_h;
    logic [30:0]      w_p7_y;
    logic [28:0]      r_p7_y, n_p7_y;

    logic [63:0]      w_rnd;
    logic [63:0]      w_lim;
    logic [SAMPLE_BITS-1:0] w_r;
    logic [SAMPLE_BITS-1:0] r_out, n_out;

    // Stage 1: split the sample into sign and Q.28 magnitude.
    always_comb begin
        w_raw     = i_sample_in;
        w_mag     = w_raw[SAMPLE_BITS-1] ? (~w_raw + SAMPLE_BITS'(1)) : w_raw;
        n_side0.neg = w_raw[SAMPLE_BITS-1];
        n_side0.x   = 32'(w_mag) << (32 - SAMPLE_BITS);
        n_side0.lin = 1'b0;
        n_side0.sat = 1'b0;
    end

    // Stages 2 to 4: p = x * (1 + x + x^2) for the cubic rational curve,
    // with the wide product taken as two partial products.
    always_comb begin
        w_pr2     = 64'(r_side[0].x) * 64'(r_side[0].x);
        n_s2_x2   = 35'((w_pr2 + HALF64) >> 28);
        w_s3_sum  = 35'(ONE64) + 35'(r_side[1].x) + r_s2_x2;
        n_s3_pl   = 50'(r_side[1].x) * 50'(w_s3_sum[17:0]);
        n_s3_ph   = 49'(r_side[1].x) * 49'(w_s3_sum[34:18]);
        w_s4_prod = {r_s3_ph, 18'b0} + 67'(r_s3_pl);
        n_s4_p    = DEN_BITS'((w_s4_prod + 67'(HALF64)) >> 28);
    end

    // Stage 5: divider operands. The ratio curves need round(2^56 / d); the
    // soft clip needs the knee-scaled argument, which saturates early when
    // the quotient would not fit 30 bits.
    always_comb begin
        w_d1   = DEN_BITS'(r_side[3].x) + DEN_BITS'(ONE64);
        w_d2   = r_s4_p + DEN_BITS'(ONE64);
        w_den6 = DEN_BITS'(ONE64) - DEN_BITS'(w_knee_q);
        w_diff = 33'(r_side[3].x) - 33'(w_knee_q);
        n_lin  = r_side[3].x <= 32'(w_knee_q);
        n_sat  = !n_lin && (w_diff[31:0] >= 32'(w_den6 << 2));
        n_side5     = r_side[ST_S5-1];
        n_side5.lin = n_lin;
        n_side5.sat = n_sat;
        case (r_shape_mode)
            SHAPE_RATIONAL: begin
                n_s5_den = w_d1;
                n_s5_num = NUM_BITS'(RATIO_NUM) + NUM_BITS'(w_d1 >> 1);
            end
            SHAPE_CUBIC_RAT: begin
                n_s5_den = w_d2;
                n_s5_num = NUM_BITS'(RATIO_NUM) + NUM_BITS'(w_d2 >> 1);
            end
            SHAPE_HEXIC_SOFT: begin
                n_s5_den = w_den6;
                n_s5_num = {w_diff[29:0], 28'b0};
            end
            default: begin
                n_s5_den = DEN_BITS'(ONE64);
                n_s5_num = '0;
            end
        endcase
    end

    // Divider: one restoring step per stage. The numerator is below 2^30
    // times the denominator, so 30 steps give the whole quotient.
    always_comb begin
        w_dv_rem_in[0] = DEN_BITS'(r_s5_num[NUM_BITS-1:DIV_STEPS]);
        w_dv_num_in[0] = r_s5_num[DIV_STEPS-1:0];
        w_dv_q_in[0]   = '0;
        w_dv_den_in[0] = r_s5_den;
        for (int j = 1; j < DIV_STEPS; j++) begin
            w_dv_rem_in[j] = r_dv_rem[j-1];
            w_dv_num_in[j] = r_dv_num[j-1];
            w_dv_q_in[j]   = r_dv_q[j-1];
            w_dv_den_in[j] = r_dv_den[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            w_dv_trial[j] = {w_dv_rem_in[j], w_dv_num_in[j][DIV_STEPS-1]};
            n_dv_num[j]   = {w_dv_num_in[j][DIV_STEPS-2:0], 1'b0};
            n_dv_den[j]   = w_dv_den_in[j];
            if (w_dv_trial[j] >= {1'b0, w_dv_den_in[j]}) begin
                n_dv_rem[j] = DEN_BITS'(w_dv_trial[j] - {1'b0, w_dv_den_in[j]});
                n_dv_q[j]   = {w_dv_q_in[j][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_dv_rem[j] = DEN_BITS'(w_dv_trial[j]);
                n_dv_q[j]   = {w_dv_q_in[j][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    // Quotient stage: pick the polynomial argument. Clip and ratio results
    // are finished here and ride the argument lane to the end.
    always_comb begin
        w_q      = r_dv_q[DIV_STEPS-1];
        w_q6_big = 1'b0;
        w_q6_z   = r_side[ST_Q-1].x[29:0];
        case (r_shape_mode)
            SHAPE_RATIONAL, SHAPE_CUBIC_RAT: begin
                w_q6_z = 30'(ONE64) - w_q;
            end
            SHAPE_CUBIC: begin
                w_q6_big = r_side[ST_Q-1].x > 32'(CUBIC_LIM);
            end
            SHAPE_QUARTIC, SHAPE_HEXIC: begin
                w_q6_big = r_side[ST_Q-1].x > 32'(TWO64);
            end
            SHAPE_HEXIC_SOFT: begin
                w_q6_big = r_side[ST_Q-1].sat || (w_q > 30'(TWO64));
                w_q6_z   = w_q;
            end
            default: begin
                if (r_side[ST_Q-1].x > 32'(ONE64)) begin
                    w_q6_z = 30'(ONE64);
                end
            end
        endcase
        n_q6_z = w_q6_big ? 30'd0 : w_q6_z;
    end

    // Polynomial stages: powers of the argument, each product rounded.
    always_comb begin
        n_p1_z2  = 31'((60'(r_q6_z) * 60'(r_q6_z) + 60'(HALF64)) >> 28);
        n_p2_z3  = 32'((61'(r_p1_z2) * 61'(r_p1_z) + 61'(HALF64)) >> 28);
        n_p2_z4  = 33'((62'(r_p1_z2) * 62'(r_p1_z2) + 62'(HALF64)) >> 28);
        n_p3_z5  = 34'((63'(r_p2_z4) * 63'(r_p2_z) + 63'(HALF64)) >> 28);
        n_p3_z6  = 35'((64'(r_p2_z4) * 64'(r_p2_z2) + HALF64) >> 28);
        w_n27    = {r_p2_z3[29:0], 2'b00} + 32'd13;
        w_pr27   = 65'(w_n27) * 65'(DIV27_MUL);
        n_p3_t27 = 28'(w_pr27 >> DIV27_SHIFT);
        n_p3_s4  = (40'(r_p2_z) << 4) - (40'(r_p2_z3) << 2) + 40'(r_p2_z4) + 40'd8;
        n_p3_a6  = (40'(r_p2_z) << 5) - (40'(r_p2_z4) << 3) - (40'(r_p2_z4) << 1)
                   + 40'd16;
        n_p4_s6  = r_p3_a6 + (40'(r_p3_z5) << 2) + (40'(r_p3_z5) << 1) - 40'(r_p3_z6);
    end

    // Curve selection, limited to zero from below and forced to one past
    // the end of the curve.
    always_comb begin
        case (r_shape_mode)
            SHAPE_CUBIC: begin
                n_p5_h = (30'(r_p4_t27) > r_p4_z) ? 30'd0 : (r_p4_z - 30'(r_p4_t27));
            end
            SHAPE_QUARTIC: begin
                n_p5_h = r_p4_s4[39] ? 30'd0 : 30'(r_p4_s4 >> 4);
            end
            SHAPE_HEXIC, SHAPE_HEXIC_SOFT: begin
                n_p5_h = r_p4_s6[39] ? 30'd0 : 30'(r_p4_s6 >> 5);
            end
            default: begin
                n_p5_h = r_p4_z;
            end
        endcase
        if (r_p4_big) begin
            n_p5_h = 30'(ONE64);
        end
    end

    // Soft clip: rescale the hexic value above the knee.
    always_comb begin
        n_p6_m = 59'(30'(ONE64) - 30'(w_knee_q)) * 59'(r_p5_h);
        if (r_shape_mode == SHAPE_HEXIC_SOFT) begin
            if (r_side[ST_P7-1].lin) begin
                w_p7_y = 31'(r_side[ST_P7-1].x);
            end else begin
                w_p7_y = 31'(w_knee_q) + 31'((r_p6_m + 59'(HALF64)) >> 28);
            end
        end else begin
            w_p7_y = 31'(r_p6_h);
        end
        n_p7_y = (w_p7_y > 31'(ONE64)) ? 29'(ONE64) : 29'(w_p7_y);
    end

    // Output: round to the Q2 format, halves away from zero after the sign.
    always_comb begin
        w_rnd = ((64'(r_p7_y) + RND_HALF) >> RSH) << LSH;
        w_lim = (w_rnd > ONE_OUT) ? ONE_OUT : w_rnd;
        w_r   = w_lim[SAMPLE_BITS-1:0];
        n_out = r_side[ST_P7].neg ? (~w_r + SAMPLE_BITS'(1)) : w_r;
    end

    assign o_sample_out = r_out;

    // ------------------------------------------------------------------
    // Pipeline registers (payload, no reset).
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < NSTG - 1; k++) begin
                r_side[k] <= (k == ST_S5) ? n_side5 : r_side[k-1];
            end

            r_s2_x2  <= n_s2_x2;
            r_s3_pl  <= n_s3_pl;
            r_s3_ph  <= n_s3_ph;
            r_s4_p   <= n_s4_p;
            r_s5_num <= n_s5_num;
            r_s5_den <= n_s5_den;

            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_num[j] <= n_dv_num[j];
                r_dv_q[j]   <= n_dv_q[j];
                r_dv_den[j] <= n_dv_den[j];
            end

            r_q6_z   <= n_q6_z;
            r_q6_big <= w_q6_big;

            r_p1_z   <= r_q6_z;
            r_p1_z2  <= n_p1_z2;
            r_p1_big <= r_q6_big;

            r_p2_z   <= r_p1_z;
            r_p2_z2  <= r_p1_z2;
            r_p2_z3  <= n_p2_z3;
            r_p2_z4  <= n_p2_z4;
            r_p2_big <= r_p1_big;

            r_p3_z   <= r_p2_z;
            r_p3_z5  <= n_p3_z5;
            r_p3_z6  <= n_p3_z6;
            r_p3_t27 <= n_p3_t27;
            r_p3_s4  <= n_p3_s4;
            r_p3_a6  <= n_p3_a6;
            r_p3_big <= r_p2_big;

            r_p4_z   <= r_p3_z;
            r_p4_t27 <= r_p3_t27;
            r_p4_s4  <= r_p3_s4;
            r_p4_s6  <= n_p4_s6;
            r_p4_big <= r_p3_big;

            r_p5_h   <= n_p5_h;
            r_p6_m   <= n_p6_m;
            r_p6_h   <= r_p5_h;
            r_p7_y   <= n_p7_y;
            r_out    <= n_out;
        end
    end

endmodule

`default_nettype wire
